@@ design/sssf_pkg.sv @@
package sssf_pkg;

  localparam int FRAME_DIGITS    = 6;
  localparam int DIGIT_W         = 4;
  localparam int SEG_W           = 8;
  localparam int GROUP_W         = 10;
  localparam int CFG_INDEX_W     = 1;
  localparam int CFG_DATA_W      = 1;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [GROUP_W-1:0] GROUP_MAX = 10'd999;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_BIT_ORDER    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMMON_ANODE = 1'b1;

  // One classified item: a BCD digit per display position and its lit flag.
  typedef struct packed {
    logic [FRAME_DIGITS-1:0][DIGIT_W-1:0] digits;
    logic [FRAME_DIGITS-1:0]              lit;
  } entry_t;

  // Segment pattern, bit 7 is segment a down to bit 1 segment g, bit 0 the point.
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] p;
    case (d)
      4'd0:    p = 8'b11111100;
      4'd1:    p = 8'b01100000;
      4'd2:    p = 8'b11011010;
      4'd3:    p = 8'b11110010;
      4'd4:    p = 8'b01100110;
      4'd5:    p = 8'b10110110;
      4'd6:    p = 8'b10111110;
      4'd7:    p = 8'b11100100;
      4'd8:    p = 8'b11111110;
      4'd9:    p = 8'b11110110;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  function automatic logic [SEG_W-1:0] reverse8(input logic [SEG_W-1:0] v);
    logic [SEG_W-1:0] r;
    for (int i = 0; i < SEG_W; i++) begin
      r[i] = v[SEG_W-1-i];
    end
    return r;
  endfunction

  // Splits a value below one thousand into hundreds, tens and ones.
  // Each digit is found by comparing against the nine constant thresholds.
  function automatic logic [3*DIGIT_W-1:0] split3(input logic [GROUP_W-1:0] v);
    logic [DIGIT_W-1:0] h;
    logic [DIGIT_W-1:0] t;
    logic [GROUP_W-1:0] r;
    h = '0;
    for (int k = 1; k < 10; k++) begin
      if (v >= GROUP_W'(k * 100)) h = DIGIT_W'(k);
    end
    r = v - GROUP_W'(h * 100);
    t = '0;
    for (int k = 1; k < 10; k++) begin
      if (r >= GROUP_W'(k * 10)) t = DIGIT_W'(k);
    end
    r = r - GROUP_W'(t * 10);
    return {h, t, r[DIGIT_W-1:0]};
  endfunction

endpackage

@@ design/sssf_front.sv @@
module sssf_front (
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sssf_pkg::GROUP_W-1:0]      low_group,
  input  logic [sssf_pkg::GROUP_W-1:0]      high_group,
  input  logic                              q_full,
  output logic                              push,
  output sssf_pkg::entry_t                  entry
);
  import sssf_pkg::*;

  logic [GROUP_W-1:0]   lo_sat;
  logic [GROUP_W-1:0]   hi_sat;
  logic [3*DIGIT_W-1:0] lo_digits;
  logic [3*DIGIT_W-1:0] hi_digits;

  // Groups above range are clamped before digits and lit flags are derived.
  assign lo_sat    = (low_group  > GROUP_MAX) ? GROUP_MAX : low_group;
  assign hi_sat    = (high_group > GROUP_MAX) ? GROUP_MAX : high_group;
  assign lo_digits = split3(lo_sat);
  assign hi_digits = split3(hi_sat);

  always_comb begin
    entry.digits[0] = lo_digits[DIGIT_W-1:0];
    entry.digits[1] = lo_digits[2*DIGIT_W-1:DIGIT_W];
    entry.digits[2] = lo_digits[3*DIGIT_W-1:2*DIGIT_W];
    entry.digits[3] = hi_digits[DIGIT_W-1:0];
    entry.digits[4] = hi_digits[2*DIGIT_W-1:DIGIT_W];
    entry.digits[5] = hi_digits[3*DIGIT_W-1:2*DIGIT_W];
    entry.lit[0]    = 1'b1;
    entry.lit[1]    = lo_sat >= GROUP_W'(10);
    entry.lit[2]    = lo_sat >= GROUP_W'(100);
    entry.lit[3]    = 1'b1;
    entry.lit[4]    = hi_sat >= GROUP_W'(10);
    entry.lit[5]    = hi_sat >= GROUP_W'(100);
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule

@@ design/sssf_queue.sv @@
module sssf_queue #(
  parameter int DEPTH = sssf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sssf_pkg::entry_t wr_entry,
  output logic             full,
  input  logic             pop,
  output sssf_pkg::entry_t head,
  output logic             head_valid
);
  import sssf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("queue popped while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count above depth");
`endif

endmodule

@@ design/sssf_back.sv @@
module sssf_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sssf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sssf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  sssf_pkg::entry_t                    head,
  input  logic                                head_valid,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sssf_pkg::FRAME_DIGITS-1:0]   digit_select,
  output logic [sssf_pkg::SEG_W-1:0]          segments,
  output logic [sssf_pkg::SEG_W-1:0]          shift_word,
  output logic                                last
);
  import sssf_pkg::*;

  logic                    bit_order;
  logic                    common_anode;
  logic [FRAME_DIGITS-1:0] done;
  logic [FRAME_DIGITS-1:0] remaining;
  logic [FRAME_DIGITS-1:0] cur;
  logic [FRAME_DIGITS-1:0] rest;
  logic                    is_last;
  logic [DIGIT_W-1:0]      digit;
  logic [SEG_W-1:0]        seg_raw;
  logic [SEG_W-1:0]        seg_pol;
  logic [SEG_W-1:0]        seg_shift;
  logic                    load;

  // The lowest lit position not yet sent is the next frame.
  assign remaining = head.lit & ~done;
  assign cur       = remaining & (~remaining + 1'b1);
  assign rest      = remaining & ~cur;
  assign is_last   = rest == '0;

  always_comb begin
    digit = '0;
    for (int i = 0; i < FRAME_DIGITS; i++) begin
      digit = digit | (cur[i] ? head.digits[i] : '0);
    end
  end

  assign seg_raw   = seg_pattern(digit);
  assign seg_pol   = common_anode ? ~seg_raw : seg_raw;
  assign seg_shift = bit_order ? seg_pol : reverse8(seg_pol);
  assign load      = head_valid && (!out_valid || out_ready);
  assign pop       = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_order    <= 1'b1;
      common_anode <= 1'b1;
      done         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BIT_ORDER:    bit_order    <= cfg_data[0];
          CFG_COMMON_ANODE: common_anode <= cfg_data[0];
          default: ;
        endcase
      end
      if (load) begin
        done      <= is_last ? '0 : (done | cur);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digit_select <= cur;
      segments     <= seg_pol;
      shift_word   <= seg_shift;
      last         <= is_last;
    end
  end

`ifndef SYNTH
  a_select_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(digit_select)) else $error("digit select not one-hot");
  a_always_lit: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (head.lit[0] && head.lit[3])) else $error("ones or thousands unlit");
  a_frame_pending: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> remaining != '0) else $error("queued item with no frame left");
  a_done_cleared: assert property (@(posedge clk) disable iff (rst)
    pop |=> done == '0) else $error("sent mask kept after item end");
`endif

endmodule

@@ design/six_digit_seven_segment_frames.sv @@
// Six-digit seven-segment frame generator.
//
// Input channel (in_valid/in_ready): one beat carries low_group and
// high_group. Each group is clamped to 999, and the display value is
// high_group*1000 + low_group.
// Output channel (out_valid/out_ready): one beat per lit digit, ones first
// up to hundred-thousands. Ones and thousands are always lit; the other
// digits are lit when their group is at least 10 or 100. The last beat of an
// item has last set. Each beat carries the one-hot digit_select, the segment
// byte after polarity and the same byte in shift order.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 bit_order, 1 common_anode); write only while the block is idle.
// On an idle block an input beat is written into the queue and then loaded
// into the output register before out_valid rises. The back end sends one
// frame per cycle unless the output stalls, so an item takes two to six
// frames, set by the back-end sequencer that walks the lit digits.
// A small queue decouples the front end, so new input beats are taken while
// the output stalls until the queue fills; a stalled frame holds steady.
// Reset clears the queue, the sent mask and out_valid and sets both
// configuration registers to 1.
module six_digit_seven_segment_frames #(
  parameter int QUEUE_DEPTH = sssf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sssf_pkg::GROUP_W-1:0]      low_group,
  input  logic [sssf_pkg::GROUP_W-1:0]      high_group,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sssf_pkg::FRAME_DIGITS-1:0] digit_select,
  output logic [sssf_pkg::SEG_W-1:0]        segments,
  output logic [sssf_pkg::SEG_W-1:0]        shift_word,
  output logic                              last,
  input  logic                              cfg_we,
  input  logic [sssf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sssf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sssf_pkg::*;

  entry_t new_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   head_valid;

  // Front end: clamps the groups, splits them into digits, marks lit digits.
  sssf_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .low_group  (low_group),
    .high_group (high_group),
    .q_full     (q_full),
    .push       (push),
    .entry      (new_entry)
  );

  // Queue of classified items between the two halves.
  sssf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_entry   (new_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // Back end: emits one frame per lit digit into the output register.
  sssf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digit_select (digit_select),
    .segments     (segments),
    .shift_word   (shift_word),
    .last         (last)
  );

endmodule
